// ----- src/fourier_shell_power_binning_core_macros.svh -----
// assertion helpers shared by the checker
`ifndef FOURIER_SHELL_POWER_BINNING_CORE_MACROS_SVH
`define FOURIER_SHELL_POWER_BINNING_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSPB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FSPB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fspb_pkg.sv -----
// ----------------------------------------------------------------------------
// fspb_pkg
// shared types and constants of the shell power binning core
// ----------------------------------------------------------------------------
package fspb_pkg;

	localparam int COUNT_W = 23;
	localparam int POWER_W = 64;
	localparam int KSUM_W = 56;
	localparam int KK_W = 18;
	localparam int RAD_W = 34;
	localparam int ROOT_W = 17;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MESH_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_UNIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_SCALE = 2'd2;

	localparam logic [7:0] MESH_RESET = 8'd128;
	localparam logic [15:0] K_UNIT_RESET = 16'd4096;
	localparam logic [31:0] VOLUME_RESET = 32'd65536;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic signed [POWER_W-1:0] power;
		logic [KSUM_W-1:0] ksum;
	} entry_t;

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

// ----- src/fspb_sqrt.sv -----
// ----------------------------------------------------------------------------
// fspb_sqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module fspb_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [fspb_pkg::RAD_W-1:0] radicand,
	output logic done,
	output logic [fspb_pkg::ROOT_W-1:0] root
);
	import fspb_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic fits;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(rem_sh);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- src/fspb_div.sv -----
// ----------------------------------------------------------------------------
// fspb_div
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fspb_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [fspb_pkg::COUNT_W-1:0] divisor,
	input logic [fspb_pkg::DIV_W-1:0] num_a,
	input logic [fspb_pkg::DIV_W-1:0] num_b,
	output logic done,
	output logic [fspb_pkg::DIV_W-1:0] quo_a,
	output logic [fspb_pkg::DIV_W-1:0] quo_b
);
	import fspb_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [COUNT_W-1:0] div_q;
	logic [DIV_W-1:0] na_q;
	logic [DIV_W-1:0] nb_q;
	logic [COUNT_W-1:0] ra_q;
	logic [COUNT_W-1:0] rb_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [COUNT_W:0] sh_a;
	logic [COUNT_W:0] sh_b;
	logic ge_a;
	logic ge_b;

	assign sh_a = {ra_q, na_q[DIV_W-1]};
	assign sh_b = {rb_q, nb_q[DIV_W-1]};
	assign ge_a = sh_a >= {1'b0, div_q};
	assign ge_b = sh_b >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator registers fill up with quotient bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			na_q <= num_a;
			nb_q <= num_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (run_q) begin
			na_q <= {na_q[DIV_W-2:0], ge_a};
			nb_q <= {nb_q[DIV_W-2:0], ge_b};
			ra_q <= ge_a ? COUNT_W'(sh_a - {1'b0, div_q}) : COUNT_W'(sh_a);
			rb_q <= ge_b ? COUNT_W'(sh_b - {1'b0, div_q}) : COUNT_W'(sh_b);
		end
	end

	assign done = done_q;
	assign quo_a = na_q;
	assign quo_b = nb_q;

endmodule

// ----- src/fspb_store.sv -----
// ----------------------------------------------------------------------------
// fspb_store
// per-shell accumulator memory with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
module fspb_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output fspb_pkg::entry_t rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input fspb_pkg::entry_t wr_data,
	input logic clear_all
);
	import fspb_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;
	logic rvalid_q;
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// an entry never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
			if (clear_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// ----- src/fourier_shell_power_binning_core.sv -----
// ----------------------------------------------------------------------------
// fourier_shell_power_binning_core
// isotropic cross power spectrum binning over a stream of fourier modes
// ----------------------------------------------------------------------------
// a mode runs from request to write-back through the 17-step square root and the multiply states
// one mode at a time: the next request is taken only once the core is back in idle
// a final mode adds a readout of each shell in use through the 64-step divider and
// the 4-step volume multiply, plus any output stall
// reset is asynchronous: state and config take their defaults, all shells read as empty
module fourier_shell_power_binning_core #(
	parameter int MAX_BINS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [fspb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fspb_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [6:0] index_x,
	input logic [6:0] index_y,
	input logic [6:0] index_z,
	input logic signed [15:0] first_real,
	input logic signed [15:0] first_imag,
	input logic signed [15:0] second_real,
	input logic signed [15:0] second_imag,
	input logic final_mode,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] bin_number,
	output logic [31:0] mean_wavenumber,
	output logic signed [63:0] mean_power,
	output logic [22:0] weighted_count,
	output logic last_bin
);
	import fspb_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int NW = $clog2(MAX_BINS + 1);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_SQ_GO   = 11'b00000000010,
		S_ROOT    = 11'b00000000100,
		S_MUL_A   = 11'b00000001000,
		S_MUL_B   = 11'b00000010000,
		S_MUL_K   = 11'b00000100000,
		S_UPD     = 11'b00001000000,
		S_WRAP    = 11'b00010000000,
		S_RD_REQ  = 11'b00100000000,
		S_DIV     = 11'b01000000000,
		S_SCALE   = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] mesh_q;
	logic [15:0] kunit_q;
	logic [31:0] vol_q;

	// captured request
	logic [KK_W-1:0] kk_q;
	logic wt2_q;
	logic zero_q;
	logic final_q;
	logic signed [15:0] re1_q, im1_q, re2_q, im2_q;

	// per-mode arithmetic
	logic [AW-1:0] hbin_q;
	logic [ROOT_W-1:0] kq8_q;
	logic signed [31:0] pa_q;
	logic signed [31:0] pb_q;
	logic [ROOT_W+15:0] pk_q;

	// readout
	logic [AW-1:0] bin_q;
	logic rd_wait_q;
	logic [COUNT_W-1:0] rcount_q;
	logic pneg_q;
	logic [DIV_W-1:0] qmag_q;
	logic [31:0] mk_q;
	logic [95:0] acc_q;
	logic [1:0] scnt_q;
	logic emit_q;

	// output register
	logic out_valid_q;
	logic [5:0] obin_q;
	logic [31:0] omk_q;
	logic signed [63:0] omp_q;
	logic [COUNT_W-1:0] ocnt_q;
	logic olast_q;

	logic [6:0] half;
	logic [NW-1:0] nb;
	logic accept;
	logic slot_free;
	logic signed [8:0] fx, fy, fz;
	logic signed [17:0] sqx, sqy, sqz;
	logic [KK_W-1:0] kk_d;
	logic [ROOT_W-1:0] root;
	logic [8:0] mode_bin;
	logic hit;
	logic is_last;

	unit_ctl_t sq_ctl;
	unit_ctl_t dv_ctl;
	logic [DIV_W-1:0] quo_k;
	logic [DIV_W-1:0] quo_p;

	entry_t rd_data;
	entry_t wr_data;
	logic st_rd_en;
	logic [AW-1:0] st_rd_addr;
	logic st_wr_en;
	logic clear_all;

	logic signed [32:0] val;
	logic signed [33:0] wval;
	logic signed [64:0] psum;
	logic [COUNT_W:0] csum;
	logic [33:0] kc;
	logic [KSUM_W:0] ksum;
	logic [DIV_W-1:0] pmag;
	logic [47:0] pp;
	logic [95:0] acc_d;
	logic psat;
	logic signed [63:0] mp;

	function automatic logic signed [8:0] fold(input logic [6:0] idx, input logic [6:0] hf,
			input logic [7:0] mesh);
		logic signed [8:0] f;
		f = $signed({2'b00, idx});
		if (idx > hf) begin
			f = $signed({2'b00, idx}) - $signed({1'b0, mesh});
		end
		return f;
	endfunction

	assign half = mesh_q[7:1];
	assign nb = ({1'b0, half} < 8'(MAX_BINS)) ? NW'(half) : NW'(MAX_BINS);
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign is_last = (NW'(bin_q) + 1'b1) == nb;

	assign fx = fold(index_x, half, mesh_q);
	assign fy = fold(index_y, half, mesh_q);
	assign fz = fold(index_z, half, mesh_q);
	assign sqx = fx * fx;
	assign sqy = fy * fy;
	assign sqz = fz * fz;
	assign kk_d = KK_W'(sqx[16:0]) + KK_W'(sqy[16:0]) + KK_W'(sqz[16:0]);

	// shell is the integer part of the q.8 magnitude
	assign mode_bin = root[ROOT_W-1:8];
	assign hit = (mode_bin < 9'(nb)) && !zero_q;

	assign sq_ctl.start = (state_q == S_SQ_GO);
	fspb_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_ctl.start),
		.radicand({kk_q, 16'd0}),
		.done(sq_ctl.done),
		.root(root)
	);

	assign pmag = rd_data.power[POWER_W-1] ? DIV_W'(-rd_data.power) : DIV_W'(rd_data.power);
	assign dv_ctl.start = rd_wait_q;
	fspb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_ctl.start),
		.divisor(rd_data.count),
		.num_a(DIV_W'(rd_data.ksum)),
		.num_b(pmag),
		.done(dv_ctl.done),
		.quo_a(quo_k),
		.quo_b(quo_p)
	);

	assign st_rd_en = ((state_q == S_ROOT) && sq_ctl.done && hit) || (state_q == S_RD_REQ);
	assign st_rd_addr = (state_q == S_RD_REQ) ? bin_q : root[8 +: AW];
	assign st_wr_en = (state_q == S_UPD);
	assign clear_all = ((state_q == S_WRAP) && final_q && (nb == '0))
		|| (emit_q && slot_free && is_last);

	fspb_store #(
		.DEPTH(MAX_BINS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(st_rd_en),
		.rd_addr(st_rd_addr),
		.rd_data(rd_data),
		.wr_en(st_wr_en),
		.wr_addr(hbin_q),
		.wr_data(wr_data),
		.clear_all(clear_all)
	);

	// accumulate with saturation
	always_comb begin
		val = 33'(pa_q) + 33'(pb_q);
		wval = wt2_q ? {val, 1'b0} : 34'(val);
		psum = 65'(rd_data.power) + 65'(wval);
		csum = {1'b0, rd_data.count} + (wt2_q ? 24'd2 : 24'd1);
		kc = wt2_q ? {pk_q, 1'b0} : {1'b0, pk_q};
		ksum = {1'b0, rd_data.ksum} + (KSUM_W+1)'(kc);
		wr_data.count = csum[COUNT_W] ? '1 : csum[COUNT_W-1:0];
		if (psum[64] != psum[63]) begin
			wr_data.power = psum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			wr_data.power = psum[63:0];
		end
		wr_data.ksum = ksum[KSUM_W] ? '1 : ksum[KSUM_W-1:0];
	end

	// mean power times volume, high chunk first
	always_comb begin
		pp = qmag_q[63:48] * vol_q;
		acc_d = {acc_q[79:0], 16'd0} + 96'(pp);
		if (pneg_q) begin
			psat = (acc_q[95:64] != '0) || (acc_q[63] && (acc_q[62:0] != '0));
		end else begin
			psat = (acc_q[95:63] != '0);
		end
		if (psat) begin
			mp = pneg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			mp = pneg_q ? -$signed(acc_q[63:0]) : $signed(acc_q[63:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mesh_q <= MESH_RESET;
			kunit_q <= K_UNIT_RESET;
			vol_q <= VOLUME_RESET;
			bin_q <= '0;
			rd_wait_q <= 1'b0;
			emit_q <= 1'b0;
			scnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_MESH_SIZE: mesh_q <= cfg_data[7:0];
					REG_K_UNIT: kunit_q <= cfg_data[15:0];
					REG_VOLUME_SCALE: vol_q <= cfg_data;
					default: ;
				endcase
			end
			rd_wait_q <= (state_q == S_RD_REQ);
			if ((state_q == S_SCALE) && emit_q && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_SQ_GO;
				S_SQ_GO: state_q <= S_ROOT;
				S_ROOT: if (sq_ctl.done) state_q <= hit ? S_MUL_A : S_WRAP;
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_K;
				S_MUL_K: state_q <= S_UPD;
				S_UPD: state_q <= S_WRAP;
				S_WRAP: begin
					bin_q <= '0;
					if (final_q && (nb != '0)) begin
						state_q <= S_RD_REQ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD_REQ: state_q <= S_DIV;
				S_DIV: if (dv_ctl.done) begin
					state_q <= S_SCALE;
					scnt_q <= '0;
				end
				S_SCALE: begin
					if (!emit_q) begin
						scnt_q <= scnt_q + 1'b1;
						if (scnt_q == 2'd3) emit_q <= 1'b1;
					end else if (slot_free) begin
						emit_q <= 1'b0;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							bin_q <= bin_q + 1'b1;
							state_q <= S_RD_REQ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kk_q <= kk_d;
			wt2_q <= !((index_z == 7'd0) || (index_z == half));
			zero_q <= (index_x == 7'd0) && (index_y == 7'd0) && (index_z == 7'd0);
			final_q <= final_mode;
			re1_q <= first_real;
			im1_q <= first_imag;
			re2_q <= second_real;
			im2_q <= second_imag;
		end
		if ((state_q == S_ROOT) && sq_ctl.done) begin
			kq8_q <= root;
			hbin_q <= root[8 +: AW];
		end
		if (state_q == S_MUL_A) pa_q <= re1_q * re2_q;
		if (state_q == S_MUL_B) pb_q <= im1_q * im2_q;
		if (state_q == S_MUL_K) pk_q <= kq8_q * kunit_q;
		if (rd_wait_q) begin
			rcount_q <= rd_data.count;
			pneg_q <= rd_data.power[POWER_W-1];
		end
		if ((state_q == S_DIV) && dv_ctl.done) begin
			qmag_q <= quo_p;
			mk_q <= (quo_k[63:32] != '0) ? '1 : quo_k[31:0];
			acc_q <= '0;
		end
		if ((state_q == S_SCALE) && !emit_q) begin
			acc_q <= acc_d;
			qmag_q <= {qmag_q[47:0], 16'd0};
		end
		if ((state_q == S_SCALE) && emit_q && slot_free) begin
			obin_q <= 6'(bin_q);
			omk_q <= (rcount_q == '0) ? '0 : mk_q;
			omp_q <= (rcount_q == '0) ? '0 : mp;
			ocnt_q <= rcount_q;
			olast_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_number = obin_q;
	assign mean_wavenumber = omk_q;
	assign mean_power = omp_q;
	assign weighted_count = ocnt_q;
	assign last_bin = olast_q;

endmodule

// ----- src/fspb_checker.sv -----
// ----------------------------------------------------------------------------
// fspb_checker
// port-level checks on the binning core, bound to the top level
// ----------------------------------------------------------------------------
`include "fourier_shell_power_binning_core_macros.svh"

module fspb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] mean_wavenumber,
	input logic signed [63:0] mean_power,
	input logic [22:0] weighted_count,
	input logic last_bin
);

	// a held result stays valid and keeps its mean power
	`FSPB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mean_power), "result changed while stalled")

	// one mode at a time
	`FSPB_ASSERT_NXT(a_busy_after_request, in_valid && !in_stall, in_stall, "request taken while busy")

	// readout ends with the last shell
	`FSPB_ASSERT_NXT(a_last_ends_run, out_valid && !out_stall && last_bin, !out_valid, "result after last shell")

	// no new request while a readout is still running
	`FSPB_ASSERT_IMP(a_readout_blocks, out_valid && !last_bin, in_stall, "request open during readout")

	// empty shells report zero means
	`FSPB_ASSERT_IMP(a_empty_zero, out_valid && (weighted_count == 23'd0), (mean_wavenumber == 32'd0) && (mean_power == 64'sd0), "empty shell with nonzero mean")

endmodule

bind fourier_shell_power_binning_core fspb_checker u_fspb_checker (.*);
